/* hw/rtl/dras_pkg.sv */
// dras_pkg: types, status codes and constants shared by the dns response parser
// used by dras_parser and dns_response_address_parser_core, depends on nothing
`default_nettype none

package dras_pkg;

  // parse sections of the message
  typedef enum logic [3:0] {
    PH_HDR    = 4'd0,
    PH_QLEN   = 4'd1,
    PH_QLAB   = 4'd2,
    PH_QFIX   = 4'd3,
    PH_AFIRST = 4'd4,
    PH_APTR   = 4'd5,
    PH_ALEN   = 4'd6,
    PH_ALAB   = 4'd7,
    PH_ARR    = 4'd8,
    PH_ADATA  = 4'd9,
    PH_DONE   = 4'd10,
    PH_EXTRA  = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_RESPONSE = 3'd1,
    ST_RCODE_ERROR  = 3'd2,
    ST_LENGTH_ERROR = 3'd3,
    ST_NO_ADDRESS   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] address;
    logic        id_mismatch;
  } result_item_t;

  localparam logic [15:0] EXPECTED_ID_RESET = 16'd6828;

  // first name byte above this marks a compression pointer
  localparam logic [7:0]  LABEL_LEN_MAX = 8'd63;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] A_DATA_LEN = 16'd4;

endpackage

`default_nettype wire

/* hw/rtl/dras_parser.sv */
// dras_parser: phase machine and counters that walk a dns response one byte per step
// depends on dras_pkg; produces the result for the byte being stepped
`default_nettype none

module dras_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire dras_pkg::byte_item_t  item,
  input  wire logic [15:0]           expected_id,
  output dras_pkg::result_item_t     result
);

  localparam logic [3:0] POS_ID_HI = 4'd0;
  localparam logic [3:0] POS_ID_LO = 4'd1;
  localparam logic [3:0] POS_FLAGS = 4'd2;
  localparam logic [3:0] POS_RCODE = 4'd3;
  localparam logic [3:0] POS_QD_HI = 4'd4;
  localparam logic [3:0] POS_QD_LO = 4'd5;
  localparam logic [3:0] POS_AN_HI = 4'd6;
  localparam logic [3:0] POS_AN_LO = 4'd7;
  localparam logic [3:0] POS_HDR_LAST = 4'd11;
  localparam logic [3:0] POS_FIX_LAST = 4'd3;
  localparam logic [3:0] POS_TYPE_HI = 4'd0;
  localparam logic [3:0] POS_TYPE_LO = 4'd1;
  localparam logic [3:0] POS_LEN_HI = 4'd8;
  localparam logic [3:0] POS_RR_LAST = 4'd9;

  dras_pkg::phase_t phase, phase_next;
  logic [3:0]  field_position, field_position_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] answers_left, answers_left_next;
  logic [7:0]  label_bytes_left, label_bytes_left_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] data_bytes_left, data_bytes_left_next;
  logic [31:0] address_shift, address_shift_next;
  logic [31:0] captured_address, captured_address_next;
  logic        record_found, record_found_next;
  logic        id_bad, id_bad_next;
  logic [2:0]  error_code, error_code_next;

  logic [7:0]  b;
  logic [7:0]  label_dec;
  logic [15:0] questions_dec;
  logic [15:0] answers_dec;
  logic [15:0] data_dec;
  logic [15:0] data_len_full;
  logic [31:0] shift_in;

  assign b             = item.msg_byte;
  assign label_dec     = label_bytes_left - 8'd1;
  assign questions_dec = questions_left - 16'd1;
  assign answers_dec   = answers_left - 16'd1;
  assign data_dec      = data_bytes_left - 16'd1;
  assign data_len_full = {data_bytes_left[15:8], b};
  assign shift_in      = {address_shift[23:0], b};

  always_comb begin
    phase_next            = phase;
    field_position_next   = field_position;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    label_bytes_left_next = label_bytes_left;
    record_type_next      = record_type;
    data_bytes_left_next  = data_bytes_left;
    address_shift_next    = address_shift;
    captured_address_next = captured_address;
    record_found_next     = record_found;
    id_bad_next           = id_bad;
    error_code_next       = error_code;

    unique case (phase)
      dras_pkg::PH_HDR: begin
        unique case (field_position)
          POS_ID_HI: if (b != expected_id[15:8]) id_bad_next = 1'b1;
          POS_ID_LO: if (b != expected_id[7:0]) id_bad_next = 1'b1;
          POS_FLAGS: if (!b[7]) error_code_next = dras_pkg::ST_NOT_RESPONSE;
          POS_RCODE: begin
            if (error_code == dras_pkg::ST_OK && b[3:0] != 4'd0) begin
              error_code_next = dras_pkg::ST_RCODE_ERROR;
            end
          end
          POS_QD_HI: questions_left_next = {b, 8'd0};
          POS_QD_LO: questions_left_next = {questions_left[15:8], b};
          POS_AN_HI: answers_left_next = {b, 8'd0};
          POS_AN_LO: answers_left_next = {answers_left[15:8], b};
          default: ;
        endcase
        if (field_position == POS_HDR_LAST) begin
          field_position_next = 4'd0;
          if (questions_left != 16'd0) begin
            phase_next = dras_pkg::PH_QLEN;
          end else begin
            phase_next = (answers_left != 16'd0) ? dras_pkg::PH_AFIRST : dras_pkg::PH_DONE;
          end
        end else begin
          field_position_next = field_position + 4'd1;
        end
      end
      dras_pkg::PH_QLEN: begin
        if (b == 8'd0) begin
          phase_next          = dras_pkg::PH_QFIX;
          field_position_next = 4'd0;
        end else begin
          label_bytes_left_next = b;
          phase_next            = dras_pkg::PH_QLAB;
        end
      end
      dras_pkg::PH_QLAB: begin
        label_bytes_left_next = label_dec;
        if (label_dec == 8'd0) phase_next = dras_pkg::PH_QLEN;
      end
      dras_pkg::PH_QFIX: begin
        if (field_position == POS_FIX_LAST) begin
          field_position_next = 4'd0;
          questions_left_next = questions_dec;
          if (questions_dec != 16'd0) begin
            phase_next = dras_pkg::PH_QLEN;
          end else begin
            phase_next = (answers_left != 16'd0) ? dras_pkg::PH_AFIRST : dras_pkg::PH_DONE;
          end
        end else begin
          field_position_next = field_position + 4'd1;
        end
      end
      dras_pkg::PH_AFIRST, dras_pkg::PH_ALEN: begin
        if (phase == dras_pkg::PH_AFIRST && b > dras_pkg::LABEL_LEN_MAX) begin
          phase_next = dras_pkg::PH_APTR;
        end else if (b == 8'd0) begin
          phase_next          = dras_pkg::PH_ARR;
          field_position_next = 4'd0;
        end else begin
          label_bytes_left_next = b;
          phase_next            = dras_pkg::PH_ALAB;
        end
      end
      dras_pkg::PH_APTR: begin
        phase_next          = dras_pkg::PH_ARR;
        field_position_next = 4'd0;
      end
      dras_pkg::PH_ALAB: begin
        label_bytes_left_next = label_dec;
        if (label_dec == 8'd0) phase_next = dras_pkg::PH_ALEN;
      end
      dras_pkg::PH_ARR: begin
        unique case (field_position)
          POS_TYPE_HI: record_type_next = {b, 8'd0};
          POS_TYPE_LO: record_type_next = {record_type[15:8], b};
          POS_LEN_HI:  data_bytes_left_next = {b, 8'd0};
          default: ;
        endcase
        if (field_position == POS_RR_LAST) begin
          field_position_next  = 4'd0;
          data_bytes_left_next = data_len_full;
          // from here record_type only flags an address record to capture
          record_type_next = (record_type == dras_pkg::TYPE_A &&
                              data_len_full == dras_pkg::A_DATA_LEN) ?
                             dras_pkg::TYPE_A : 16'd0;
          address_shift_next = 32'd0;
          if (data_len_full == 16'd0) begin
            answers_left_next = answers_dec;
            phase_next = (answers_dec != 16'd0) ? dras_pkg::PH_AFIRST : dras_pkg::PH_DONE;
          end else begin
            phase_next = dras_pkg::PH_ADATA;
          end
        end else begin
          field_position_next = field_position + 4'd1;
        end
      end
      dras_pkg::PH_ADATA: begin
        address_shift_next   = shift_in;
        data_bytes_left_next = data_dec;
        if (data_dec == 16'd0) begin
          if (record_type == dras_pkg::TYPE_A) begin
            captured_address_next = shift_in;
            record_found_next     = 1'b1;
          end
          answers_left_next = answers_dec;
          phase_next = (answers_dec != 16'd0) ? dras_pkg::PH_AFIRST : dras_pkg::PH_DONE;
        end
      end
      default: phase_next = dras_pkg::PH_EXTRA;
    endcase
  end

  // status is judged on the state after the final byte
  always_comb begin
    result.id_mismatch = id_bad_next;
    priority if (error_code_next != dras_pkg::ST_OK) begin
      result.status = error_code_next;
    end else if (phase_next == dras_pkg::PH_HDR && field_position_next < POS_RCODE) begin
      result.status = dras_pkg::ST_NOT_RESPONSE;
    end else if (phase_next != dras_pkg::PH_DONE) begin
      result.status = dras_pkg::ST_LENGTH_ERROR;
    end else if (!record_found_next) begin
      result.status = dras_pkg::ST_NO_ADDRESS;
    end else begin
      result.status = dras_pkg::ST_OK;
    end
    result.address = (result.status == dras_pkg::ST_OK) ? captured_address_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.final_byte)) begin
      phase            <= dras_pkg::PH_HDR;
      field_position   <= 4'd0;
      questions_left   <= 16'd0;
      answers_left     <= 16'd0;
      label_bytes_left <= 8'd0;
      record_type      <= 16'd0;
      data_bytes_left  <= 16'd0;
      address_shift    <= 32'd0;
      captured_address <= 32'd0;
      record_found     <= 1'b0;
      id_bad           <= 1'b0;
      error_code       <= dras_pkg::ST_OK;
    end else if (step) begin
      phase            <= phase_next;
      field_position   <= field_position_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      label_bytes_left <= label_bytes_left_next;
      record_type      <= record_type_next;
      data_bytes_left  <= data_bytes_left_next;
      address_shift    <= address_shift_next;
      captured_address <= captured_address_next;
      record_found     <= record_found_next;
      id_bad           <= id_bad_next;
      error_code       <= error_code_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dns_response_address_parser_core.sv */
// dns_response_address_parser_core: top level with input register, parser and result register
// depends on dras_pkg and dras_parser
`default_nettype none

// Takes a dns response one byte per transfer, final_byte set on the last byte, and
// sustains one byte per clock while no final byte waits: each byte moves from the
// input register through the phase machine in dras_parser. result_valid is a
// register, set when the final byte leaves the input register. A final byte waits
// in the input register only while the previous result is still untaken, so
// byte_ready drops only then.
// expected_id is written through the cfg channel, which is always ready.
module dns_response_address_parser_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   byte_valid,
  output logic                        byte_ready,
  input  wire dras_pkg::byte_item_t   byte_data,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output dras_pkg::result_item_t      result_data
);

  logic                   s_valid;
  dras_pkg::byte_item_t   s_item;
  logic                   advance;
  logic [15:0]            expected_id;
  dras_pkg::result_item_t parsed;

  assign cfg_ready  = 1'b1;
  assign advance    = s_valid && (!s_item.final_byte || !result_valid || result_ready);
  assign byte_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= dras_pkg::EXPECTED_ID_RESET;
    end else if (cfg_valid) begin
      expected_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (byte_ready) begin
      s_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s_item <= byte_data;
    end
  end

  dras_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (s_item),
    .expected_id (expected_id),
    .result      (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s_item.final_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_item.final_byte) begin
      result_data <= parsed;
    end
  end

  // address only goes out with an ok status
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != dras_pkg::ST_OK |-> result_data.address == 32'd0)
    else $error("address given with a failing status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.status <= dras_pkg::ST_NO_ADDRESS)
    else $error("status code out of range");

  // input side stalls only behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> s_valid && s_item.final_byte && result_valid && !result_ready)
    else $error("input stalled without a pending result");

  a_final_result: assert property (@(posedge clk) disable iff (rst)
    advance && s_item.final_byte |=> result_valid)
    else $error("final byte transfer gave no result");

endmodule

`default_nettype wire

/* verif/dns_response_address_parser_core_tb.sv */
// dns_response_address_parser_core_tb: byte-stream stimulus, a parser predictor and a checker
// drives whole dns responses, broken ones and noise through the core and checks every result
// depends on dras_pkg and the dns_response_address_parser_core rtl
`timescale 1ns / 100ps

class answer_checker;
  logic [15:0]            expected_id;
  dras_pkg::phase_t       phase;
  logic [3:0]             field_pos;
  logic [15:0]            questions_left;
  logic [15:0]            answers_left;
  logic [7:0]             label_left;
  logic [15:0]            rec_type;
  logic [15:0]            data_left;
  logic [31:0]            addr_shift;
  logic [31:0]            addr_captured;
  bit                     rec_is_a;
  bit                     addr_found;
  bit                     id_bad;
  dras_pkg::status_t      err_code;
  dras_pkg::result_item_t pending_results[$];
  int                     errors;

  function new();
    expected_id = dras_pkg::EXPECTED_ID_RESET;
    errors      = 0;
    restart();
  endfunction

  function void restart();
    phase          = dras_pkg::PH_HDR;
    field_pos      = '0;
    questions_left = '0;
    answers_left   = '0;
    label_left     = '0;
    rec_type       = '0;
    data_left      = '0;
    addr_shift     = '0;
    addr_captured  = '0;
    rec_is_a       = 1'b0;
    addr_found     = 1'b0;
    id_bad         = 1'b0;
    err_code       = dras_pkg::ST_OK;
  endfunction

  function void open_answers();
    phase = (answers_left != 0) ? dras_pkg::PH_AFIRST : dras_pkg::PH_DONE;
  endfunction

  function void next_record();
    answers_left = answers_left - 16'd1;
    open_answers();
  endfunction

  function void parse_byte(logic [7:0] b);
    case (phase)
      dras_pkg::PH_HDR: begin
        case (field_pos)
          4'd0: if (b != expected_id[15:8]) id_bad = 1'b1;
          4'd1: if (b != expected_id[7:0]) id_bad = 1'b1;
          4'd2: if (!b[7]) err_code = dras_pkg::ST_NOT_RESPONSE;
          4'd3: begin
            if (err_code == dras_pkg::ST_OK && b[3:0] != 4'd0) begin
              err_code = dras_pkg::ST_RCODE_ERROR;
            end
          end
          4'd4: questions_left = {b, 8'h00};
          4'd5: questions_left[7:0] = b;
          4'd6: answers_left = {b, 8'h00};
          4'd7: answers_left[7:0] = b;
          default: ;
        endcase
        if (field_pos == 4'd11) begin
          field_pos = '0;
          if (questions_left != 0) phase = dras_pkg::PH_QLEN;
          else open_answers();
        end else begin
          field_pos = field_pos + 4'd1;
        end
      end
      dras_pkg::PH_QLEN: begin
        if (b == 8'd0) begin
          phase     = dras_pkg::PH_QFIX;
          field_pos = '0;
        end else begin
          label_left = b;
          phase      = dras_pkg::PH_QLAB;
        end
      end
      dras_pkg::PH_QLAB: begin
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) phase = dras_pkg::PH_QLEN;
      end
      dras_pkg::PH_QFIX: begin
        if (field_pos == 4'd3) begin
          field_pos      = '0;
          questions_left = questions_left - 16'd1;
          if (questions_left != 0) phase = dras_pkg::PH_QLEN;
          else open_answers();
        end else begin
          field_pos = field_pos + 4'd1;
        end
      end
      dras_pkg::PH_AFIRST, dras_pkg::PH_ALEN: begin
        // only the first byte of an answer name can be a pointer
        if (phase == dras_pkg::PH_AFIRST && b > dras_pkg::LABEL_LEN_MAX) begin
          phase = dras_pkg::PH_APTR;
        end else if (b == 8'd0) begin
          phase     = dras_pkg::PH_ARR;
          field_pos = '0;
        end else begin
          label_left = b;
          phase      = dras_pkg::PH_ALAB;
        end
      end
      dras_pkg::PH_APTR: begin
        phase     = dras_pkg::PH_ARR;
        field_pos = '0;
      end
      dras_pkg::PH_ALAB: begin
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) phase = dras_pkg::PH_ALEN;
      end
      dras_pkg::PH_ARR: begin
        case (field_pos)
          4'd0: rec_type = {b, 8'h00};
          4'd1: rec_type[7:0] = b;
          4'd8: data_left = {b, 8'h00};
          4'd9: data_left[7:0] = b;
          default: ;
        endcase
        if (field_pos == 4'd9) begin
          field_pos  = '0;
          rec_is_a   = (rec_type == dras_pkg::TYPE_A && data_left == dras_pkg::A_DATA_LEN);
          addr_shift = '0;
          if (data_left == 0) next_record();
          else phase = dras_pkg::PH_ADATA;
        end else begin
          field_pos = field_pos + 4'd1;
        end
      end
      dras_pkg::PH_ADATA: begin
        addr_shift = {addr_shift[23:0], b};
        data_left  = data_left - 16'd1;
        if (data_left == 0) begin
          if (rec_is_a) begin
            addr_captured = addr_shift;
            addr_found    = 1'b1;
          end
          next_record();
        end
      end
      default: phase = dras_pkg::PH_EXTRA;
    endcase
  endfunction

  function void note_byte(dras_pkg::byte_item_t it);
    dras_pkg::result_item_t r;
    dras_pkg::status_t      st;
    parse_byte(it.msg_byte);
    if (it.final_byte) begin
      if (err_code != dras_pkg::ST_OK) st = err_code;
      else if (phase == dras_pkg::PH_HDR && field_pos < 4'd3) st = dras_pkg::ST_NOT_RESPONSE;
      else if (phase != dras_pkg::PH_DONE) st = dras_pkg::ST_LENGTH_ERROR;
      else if (!addr_found) st = dras_pkg::ST_NO_ADDRESS;
      else st = dras_pkg::ST_OK;
      r.status      = st;
      r.address     = (st == dras_pkg::ST_OK) ? addr_captured : 32'd0;
      r.id_mismatch = id_bad;
      pending_results.push_back(r);
      restart();
    end
  endfunction

  function void check_result(dras_pkg::result_item_t got);
    dras_pkg::result_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d address %h", got.status, got.address);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.address !== want.address) begin
      $error("address: expected %h, got %h", want.address, got.address);
      errors++;
    end
    if (got.id_mismatch !== want.id_mismatch) begin
      $error("id_mismatch: expected %0d, got %0d", want.id_mismatch, got.id_mismatch);
      errors++;
    end
  endfunction
endclass

module dns_response_address_parser_core_tb;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [15:0]            cfg_data;
  logic                   byte_valid;
  logic                   byte_ready;
  dras_pkg::byte_item_t   byte_data;
  logic                   result_valid;
  logic                   result_ready;
  dras_pkg::result_item_t result_data;

  answer_checker chk = new();

  logic [7:0]  msg_q[$];
  logic [15:0] cur_id = dras_pkg::EXPECTED_ID_RESET;
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  bit          hold_req = 1'b0;
  int          bytes_sent = 0;

  always #1 clk = ~clk;

  dns_response_address_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  // ---- message building ----
  function automatic void push_rand(int n);
    for (int i = 0; i < n; i++) msg_q.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [15:0] id, bit qr, logic [3:0] rcode,
                                     logic [15:0] qd, logic [15:0] an);
    logic [7:0] flags;
    logic [7:0] rc_byte;
    flags      = 8'($urandom);
    flags[7]   = qr;
    rc_byte    = 8'($urandom);
    rc_byte[3:0] = rcode;
    msg_q.push_back(id[15:8]);
    msg_q.push_back(id[7:0]);
    msg_q.push_back(flags);
    msg_q.push_back(rc_byte);
    msg_q.push_back(qd[15:8]);
    msg_q.push_back(qd[7:0]);
    msg_q.push_back(an[15:8]);
    msg_q.push_back(an[7:0]);
    push_rand(4);
  endfunction

  function automatic void put_labels(int count, int max_len);
    int len;
    for (int i = 0; i < count; i++) begin
      len = $urandom_range(1, max_len);
      msg_q.push_back(8'(len));
      push_rand(len);
    end
    msg_q.push_back(8'd0);
  endfunction

  function automatic void put_ptr();
    msg_q.push_back(8'($urandom_range(64, 255)));
    push_rand(1);
  endfunction

  function automatic void put_question();
    put_labels($urandom_range(1, 3), 12);
    push_rand(4);
  endfunction

  function automatic void put_rr(logic [15:0] rtype, logic [15:0] rdlen);
    msg_q.push_back(rtype[15:8]);
    msg_q.push_back(rtype[7:0]);
    push_rand(6);
    msg_q.push_back(rdlen[15:8]);
    msg_q.push_back(rdlen[7:0]);
    push_rand(int'(rdlen));
  endfunction

  function automatic void put_random_answer();
    if ($urandom_range(0, 1) == 0) put_ptr();
    else put_labels($urandom_range(0, 3), 20);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: put_rr(dras_pkg::TYPE_A, dras_pkg::A_DATA_LEN);
      6: put_rr(16'd5, 16'($urandom_range(1, 8)));
      7: put_rr(dras_pkg::TYPE_A, 16'($urandom_range(0, 8)));
      8: put_rr(16'($urandom), 16'($urandom_range(0, 6)));
      default: put_rr(16'd28, 16'd16);
    endcase
  endfunction

  function automatic void build_response();
    logic [15:0] id;
    logic [15:0] an_field;
    int          qd;
    int          an;
    bit          qr;
    logic [3:0]  rcode;
    id    = ($urandom_range(0, 9) != 0) ? cur_id : 16'($urandom);
    qd    = $urandom_range(0, 2);
    an    = $urandom_range(0, 3);
    qr    = ($urandom_range(0, 19) != 0);
    rcode = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'd0;
    // now and then a wild answer count that the message cannot live up to
    an_field = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'(an);
    put_header(id, qr, rcode, 16'(qd), an_field);
    for (int i = 0; i < qd; i++) put_question();
    for (int i = 0; i < an; i++) put_random_answer();
  endfunction

  function automatic void build_random_msg();
    int k;
    int cut;
    k = $urandom_range(0, 99);
    if (k < 90) build_response();
    if (k >= 70 && k < 82 && msg_q.size() > 1) begin
      cut = $urandom_range(1, msg_q.size() - 1);
      repeat (cut) void'(msg_q.pop_back());
    end else if (k >= 82 && k < 90) begin
      push_rand($urandom_range(1, 3));
    end else if (k >= 90) begin
      push_rand($urandom_range(1, 30));
    end
  endfunction

  // ---- driving ----
  task automatic send_byte(input logic [7:0] b, input bit last);
    dras_pkg::byte_item_t it;
    it.msg_byte   = b;
    it.final_byte = last;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= it;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    chk.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  task automatic wait_results_done();
    byte_valid <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_id(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_id = v;
    chk.expected_id = v;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_req = 1'b0;
        result_ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) chk.check_result(result_data);
  end

  initial begin
    #2000000;
    $display("dns_response_address_parser_core_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int msgs;
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    byte_valid <= 1'b0;
    byte_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle  = 1'b1;
    sink_idle = 1'b1;

    // directed messages, expected_id still at its reset value
    put_header(cur_id, 1'b1, 4'd0, 16'd0, 16'd1);
    put_ptr();
    put_rr(dras_pkg::TYPE_A, dras_pkg::A_DATA_LEN);
    send_msg();
    // short headers: one, two and three bytes
    msg_q.push_back(8'hFF);
    send_msg();
    msg_q.push_back(cur_id[15:8]);
    msg_q.push_back(cur_id[7:0] ^ 8'h01);
    send_msg();
    msg_q.push_back(cur_id[15:8]);
    msg_q.push_back(cur_id[7:0]);
    msg_q.push_back(8'h80);
    send_msg();
    // qr clear, rcode set, and both together
    put_header(cur_id, 1'b0, 4'd0, 16'd0, 16'd0);
    send_msg();
    put_header(cur_id, 1'b1, 4'd5, 16'd0, 16'd0);
    send_msg();
    put_header(cur_id ^ 16'h8000, 1'b0, 4'd15, 16'd0, 16'd0);
    send_msg();
    // a question label above 63 is a length, a first answer label of 63 is not a
    // pointer and 64 is; a cname, then two address records of which the last wins
    put_header(cur_id, 1'b1, 4'd0, 16'd1, 16'd3);
    msg_q.push_back(8'd64);
    push_rand(64);
    msg_q.push_back(8'd0);
    push_rand(4);
    msg_q.push_back(8'd63);
    push_rand(63);
    msg_q.push_back(8'd0);
    put_rr(16'd5, 16'd3);
    put_labels(1, 4);
    put_rr(dras_pkg::TYPE_A, dras_pkg::A_DATA_LEN);
    msg_q.push_back(8'd64);
    push_rand(1);
    put_rr(dras_pkg::TYPE_A, dras_pkg::A_DATA_LEN);
    send_msg();
    // no answers at all
    put_header(cur_id, 1'b1, 4'd0, 16'd1, 16'd0);
    put_labels(1, 4);
    push_rand(4);
    send_msg();
    // one byte too many, two bytes too few
    put_header(cur_id, 1'b1, 4'd0, 16'd0, 16'd1);
    put_ptr();
    put_rr(dras_pkg::TYPE_A, dras_pkg::A_DATA_LEN);
    push_rand(1);
    send_msg();
    put_header(cur_id, 1'b1, 4'd0, 16'd0, 16'd1);
    put_ptr();
    put_rr(dras_pkg::TYPE_A, dras_pkg::A_DATA_LEN);
    void'(msg_q.pop_back());
    void'(msg_q.pop_back());
    send_msg();
    // type a with the wrong length, and the right length on another type
    put_header(cur_id, 1'b1, 4'd0, 16'd0, 16'd2);
    put_ptr();
    put_rr(dras_pkg::TYPE_A, 16'd5);
    put_ptr();
    put_rr(16'd2, dras_pkg::A_DATA_LEN);
    send_msg();
    // empty record data, then a real address
    put_header(cur_id, 1'b1, 4'd0, 16'd0, 16'd2);
    put_ptr();
    put_rr(dras_pkg::TYPE_A, 16'd0);
    put_labels(1, 5);
    put_rr(dras_pkg::TYPE_A, dras_pkg::A_DATA_LEN);
    send_msg();
    // all-zero and all-ones bytes
    repeat (14) msg_q.push_back(8'h00);
    send_msg();
    repeat (14) msg_q.push_back(8'hFF);
    send_msg();

    // register extremes
    wait_results_done();
    write_id(16'hFFFF);
    repeat (2) begin
      build_random_msg();
      send_msg();
    end
    wait_results_done();
    write_id(16'h0000);
    repeat (2) begin
      build_random_msg();
      send_msg();
    end

    // long hold on the result side while short messages keep coming
    wait_results_done();
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (8) begin
      push_rand($urandom_range(1, 2));
      send_msg();
    end
    wait_results_done();
    write_id(16'($urandom));

    msgs = 0;
    while (bytes_sent < 560) begin
      if (msgs % 12 == 0) begin
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      if (msgs % 20 == 19) begin
        wait_results_done();
        write_id(16'($urandom));
      end
      build_random_msg();
      send_msg();
      msgs++;
    end

    // closing stretch at full rate on both sides
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (2) begin
      build_random_msg();
      send_msg();
    end
    wait_results_done();
    repeat (5) @(posedge clk);

    if (chk.errors == 0) begin
      $display("dns_response_address_parser_core_tb: done, clean");
    end else begin
      $display("dns_response_address_parser_core_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dras_pkg.sv
hw/rtl/dras_parser.sv
hw/rtl/dns_response_address_parser_core.sv
verif/dns_response_address_parser_core_tb.sv
